/* rtl/gcte_pkg.sv */
// Package: types, constants and helper functions of the graph coloring task engine.
`default_nettype none
package gcte_pkg;

  localparam int VERTICES   = 4096;
  localparam int EDGES      = 16384;
  localparam int MAX_CHUNK  = 32;
  localparam int COLOR_BITS = 32;
  localparam int VW  = $clog2(VERTICES);
  localparam int EW  = $clog2(EDGES);
  localparam int CLW = $clog2(COLOR_BITS + 1);
  localparam int LW  = $clog2(MAX_CHUNK + 1);

  localparam logic [2:0] OP_ENQ      = 3'd0;
  localparam logic [2:0] OP_SEND     = 3'd1;
  localparam logic [2:0] OP_RECV_DEG = 3'd2;
  localparam logic [2:0] OP_RECV_COL = 3'd3;
  localparam logic [2:0] OP_LOAD_V   = 3'd4;
  localparam logic [2:0] OP_LOAD_E   = 3'd5;
  localparam logic [2:0] OP_READ     = 3'd6;

  localparam logic [1:0] TT_ENQ      = 2'd0;
  localparam logic [1:0] TT_SEND     = 2'd1;
  localparam logic [1:0] TT_RECV_DEG = 2'd2;
  localparam logic [1:0] TT_RECV_COL = 2'd3;

  localparam logic [0:0] CFG_VCOUNT = 1'd0;
  localparam logic [0:0] CFG_CHUNK  = 1'd1;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [11:0] vertex;
    logic [31:0] arg0;
    logic [15:0] arg1;
    logic [4:0]  arg2;
  } in_beat_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  task_type;
    logic [11:0] task_vertex;
    logic [31:0] out_arg0;
    logic [31:0] out_arg1;
    logic [5:0]  out_arg2;
    logic        last;
  } out_beat_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the input beat
    logic rd_vtx;    // read the vertex stores
    logic update;    // evaluate and write back vertex state
    logic setup;     // compute the fan-out window
    logic rd_nb;     // issue a neighbor read
    logic emit_cont; // drive the continuation or reply beat
    logic emit_nb;   // drive a child beat from the neighbor data
    logic emit_enq;  // drive one enqueue child beat
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fan;       // the task fans out
    logic has_cont;  // a continuation beat comes first
    logic is_enq;
    logic is_read;
    logic more;      // another child remains after the current one
    logic none;      // the window holds no child
  } dp_sts_t;

  function automatic logic [CLW-1:0] first_free(input logic [COLOR_BITS-1:0] bm);
    logic [CLW-1:0] r;
    r = CLW'(COLOR_BITS);
    for (int b = COLOR_BITS - 1; b >= 0; b--) begin
      if (!bm[b]) r = CLW'(b);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/gcte_ctrl.sv */
// Controller state machine that sequences one task through the datapath.
`default_nettype none
module gcte_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  gcte_pkg::dp_sts_t      sts,
  output gcte_pkg::dp_cmd_t      cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_READ  = 8'b00000010,
    S_UPD   = 8'b00000100,
    S_SETUP = 8'b00001000,
    S_DISP  = 8'b00010000,
    S_CONT  = 8'b00100000,
    S_NB    = 8'b01000000,
    S_ENQ   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        cmd.capture = start;
        if (start) state_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd_vtx = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        if (sts.is_read) state_nxt = S_CONT;
        else if (sts.is_enq) state_nxt = S_ENQ;
        else if (!sts.fan) state_nxt = S_IDLE;
        else state_nxt = S_DISP;
      end
      // The window bounds are registered at setup, so the fan-out path is chosen here.
      S_DISP: begin
        if (sts.has_cont) state_nxt = S_CONT;
        else if (sts.none) state_nxt = S_IDLE;
        else begin
          cmd.rd_nb = 1'b1;
          state_nxt = S_NB;
        end
      end
      S_CONT: begin
        cmd.emit_cont = 1'b1;
        if (sts.is_read || sts.is_enq || sts.none) state_nxt = sts.is_enq ? S_ENQ : S_IDLE;
        else begin
          cmd.rd_nb = 1'b1;
          state_nxt = S_NB;
        end
      end
      S_NB: begin
        cmd.emit_nb = 1'b1;
        if (sts.more) cmd.rd_nb = 1'b1;
        else state_nxt = S_IDLE;
      end
      S_ENQ: begin
        if (sts.has_cont) begin
          cmd.emit_cont = 1'b1;
          if (sts.none) state_nxt = S_IDLE;
          else state_nxt = S_ENQ;
        end else if (sts.none) state_nxt = S_IDLE;
        else begin
          cmd.emit_enq = 1'b1;
          if (!sts.more) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule
`default_nettype wire

/* rtl/gcte_dp.sv */
// Datapath: vertex stores, neighbor store, counters and result formatting.
`default_nettype none
module gcte_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [0:0]           cfg_idx,
  input  wire logic [12:0]          cfg_wdata,
  input  gcte_pkg::in_beat_t        in_beat,
  input  gcte_pkg::dp_cmd_t         cmd,
  output gcte_pkg::dp_sts_t         sts,
  output logic                      out_valid,
  output gcte_pkg::out_beat_t       out_beat
);

  localparam int VW  = gcte_pkg::VW;
  localparam int EW  = gcte_pkg::EW;
  localparam int CLW = gcte_pkg::CLW;
  localparam int LW  = gcte_pkg::LW;
  localparam int CB  = gcte_pkg::COLOR_BITS;

  logic [12:0] vcount_r;
  logic [5:0]  chunk_r;

  logic [15:0]   deg_mem [gcte_pkg::VERTICES];
  logic [EW-1:0] es_mem  [gcte_pkg::VERTICES];
  logic [15:0]   pend_mem[gcte_pkg::VERTICES];
  logic [15:0]   hc_mem  [gcte_pkg::VERTICES];
  logic [CB-1:0] uc_mem  [gcte_pkg::VERTICES];
  logic [5:0]    col_mem [gcte_pkg::VERTICES];
  logic [VW-1:0] nb_mem  [gcte_pkg::EDGES];

  gcte_pkg::in_beat_t in_r;
  logic [15:0]   deg_r, pend_r, hc_r;
  logic [EW-1:0] es_r;
  logic [CB-1:0] uc_r;
  logic [5:0]    col_r;
  logic          fan_r, is_enq_r, is_read_r;
  logic [1:0]    ctype_r;
  logic [31:0]   cont_a0_r, cont_a1_r;
  logic [11:0]   cont_v_r;
  logic [5:0]    child_a2_r;
  logic [16:0]   start_r;
  logic [17:0]   pos_r;
  logic [LW-1:0] cnt_r;
  logic          has_cont_r;
  logic [VW-1:0] nb_r;
  logic [12:0]   enq_i_r;
  logic          emitted_cont_r;

  logic [LW-1:0] lim;
  assign lim = (chunk_r == 6'd0) ? LW'(1) :
               (chunk_r > 6'(gcte_pkg::MAX_CHUNK)) ? LW'(gcte_pkg::MAX_CHUNK) : LW'(chunk_r);

  logic [VW-1:0] vi;
  assign vi = in_r.vertex[VW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= 13'd0;
      chunk_r  <= 6'd8;
    end else if (cfg_we) begin
      if (cfg_idx == gcte_pkg::CFG_VCOUNT) vcount_r <= cfg_wdata;
      else chunk_r <= cfg_wdata[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) in_r <= in_beat;
    if (cmd.rd_vtx) begin
      deg_r  <= deg_mem[vi];
      es_r   <= es_mem[vi];
      pend_r <= pend_mem[vi];
      hc_r   <= hc_mem[vi];
      uc_r   <= uc_mem[vi];
      col_r  <= col_mem[vi];
    end
    if (cmd.rd_nb) nb_r <= nb_mem[pos_r[EW-1:0]];
  end

  // Evaluation of a task against the vertex state latched by the preceding read.
  logic        hi;
  logic [15:0] pend_dec, hc_inc, hc_dec;
  logic [CLW-1:0] ff;
  logic [CB-1:0]  uc_set;
  always_comb begin
    hi = (in_r.arg0[31:16] > deg_r) ||
         ((in_r.arg0[31:16] == deg_r) && (in_r.arg1 < 16'(vi)));
    pend_dec = pend_r - 16'd1;
    hc_inc = hc_r + 16'd1;
    hc_dec = hc_r - 16'd1;
    uc_set = uc_r;
    if (6'(in_r.arg2) < 6'(CB)) uc_set[in_r.arg2] = 1'b1;
    ff = gcte_pkg::first_free(uc_r);
  end

  logic [CLW-1:0] ff_set;
  assign ff_set = gcte_pkg::first_free(uc_set);

  // Fan-out window: begin = edge start + chunk start, end = edge start + degree.
  logic [17:0] begin_w, end_w, lim_end;
  logic [13:0] nv, enq_end, enq_lim;
  always_comb begin
    begin_w = 18'(es_r) + 18'(start_r);
    end_w   = 18'(es_r) + 18'(deg_r);
    lim_end = begin_w + 18'(lim);
    nv      = (vcount_r > 13'(gcte_pkg::VERTICES)) ? 14'(gcte_pkg::VERTICES) : 14'(vcount_r);
    enq_lim = (cont_a0_r > 32'(nv)) ? 14'h3fff : 14'(cont_a0_r) + 14'(lim);
    enq_end = (enq_lim > nv) ? nv : enq_lim;
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      fan_r <= 1'b0;
      is_enq_r <= (in_r.opcode == gcte_pkg::OP_ENQ);
      is_read_r <= (in_r.opcode == gcte_pkg::OP_READ);
      ctype_r <= gcte_pkg::TT_RECV_COL;
      child_a2_r <= 6'd0;
      start_r <= {1'b0, in_r.arg0[15:0]};
      cont_v_r <= in_r.vertex;
      cont_a1_r <= 32'd0;
      case (in_r.opcode)
        gcte_pkg::OP_ENQ: begin
          cont_a0_r <= in_r.arg0;
        end
        gcte_pkg::OP_SEND: begin
          if (deg_r == 16'd0) col_mem[vi] <= 6'd0;
          else fan_r <= 1'b1;
          ctype_r <= gcte_pkg::TT_SEND;
          // A chunk start of 64K or more is past any degree, so it saturates.
          start_r <= (in_r.arg0[31:16] != 16'd0) ? 17'h1ffff : 17'(in_r.arg0[15:0]);
          cont_a0_r <= in_r.arg0 + 32'(lim);
        end
        gcte_pkg::OP_RECV_DEG: begin
          pend_mem[vi] <= pend_dec;
          if (hi) hc_mem[vi] <= hc_inc;
          cont_a0_r <= {deg_r, 16'd0} | (32'(in_r.arg0[15:0]) + 32'(lim));
          if (pend_dec == 16'd0 && (hi ? hc_inc : hc_r) == 16'd0) begin
            fan_r <= 1'b1;
            col_mem[vi] <= 6'(ff);
            child_a2_r <= 6'(ff);
          end
        end
        gcte_pkg::OP_RECV_COL: begin
          cont_a0_r <= 32'(in_r.arg0[15:0]) + 32'(lim);
          if (in_r.arg0[15:0] != 16'd0) begin
            fan_r <= 1'b1;
            col_mem[vi] <= 6'(ff);
            child_a2_r <= 6'(ff);
          end else if (hi) begin
            hc_mem[vi] <= hc_dec;
            uc_mem[vi] <= uc_set;
            if (pend_r == 16'd0 && hc_dec == 16'd0) begin
              fan_r <= 1'b1;
              col_mem[vi] <= 6'(ff_set);
              child_a2_r <= 6'(ff_set);
            end else col_mem[vi] <= {1'b0, in_r.arg2};
          end
        end
        gcte_pkg::OP_LOAD_V: begin
          deg_mem[vi]  <= in_r.arg1;
          es_mem[vi]   <= in_r.arg0[EW-1:0];
          pend_mem[vi] <= in_r.arg1;
          hc_mem[vi]   <= 16'd0;
          uc_mem[vi]   <= '0;
          col_mem[vi]  <= 6'd0;
        end
        gcte_pkg::OP_LOAD_E: nb_mem[in_r.arg0[EW-1:0]] <= in_r.arg1[VW-1:0];
        gcte_pkg::OP_READ: begin
          cont_a0_r <= 32'(col_r);
          cont_a1_r <= 32'(uc_r);
        end
        default: ;
      endcase
    end

    if (cmd.setup) begin
      if (is_enq_r) begin
        has_cont_r <= (enq_end < nv);
        enq_i_r <= 13'(cont_a0_r);
        cnt_r <= (cont_a0_r >= 32'(enq_end)) ? LW'(0) : LW'(14'(enq_end) - 14'(cont_a0_r));
        cont_v_r <= 12'(enq_end);
        cont_a0_r <= 32'(enq_end);
      end else begin
        pos_r <= begin_w;
        has_cont_r <= (lim_end < end_w);
        cnt_r <= (lim_end < end_w) ? lim :
                 (begin_w >= end_w) ? LW'(0) : LW'(end_w - begin_w);
      end
      emitted_cont_r <= 1'b0;
    end else begin
      if (cmd.emit_cont) emitted_cont_r <= 1'b1;
      if (cmd.rd_nb) pos_r <= pos_r + 18'd1;
      if (cmd.emit_nb) cnt_r <= cnt_r - LW'(1);
      if (cmd.emit_enq) begin
        cnt_r <= cnt_r - LW'(1);
        enq_i_r <= enq_i_r + 13'd1;
      end
    end
  end

  assign sts.fan = fan_r;
  assign sts.has_cont = has_cont_r && !emitted_cont_r;
  assign sts.is_enq = is_enq_r;
  assign sts.is_read = is_read_r;
  assign sts.more = (cnt_r > LW'(1));
  assign sts.none = (cnt_r == LW'(0));

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= cmd.emit_cont || cmd.emit_nb || cmd.emit_enq;
    if (cmd.emit_cont) begin
      out_beat.kind <= is_read_r;
      out_beat.task_type <= is_read_r ? gcte_pkg::TT_ENQ :
                            is_enq_r ? gcte_pkg::TT_ENQ : ctype_r;
      out_beat.task_vertex <= cont_v_r;
      out_beat.out_arg0 <= cont_a0_r;
      out_beat.out_arg1 <= cont_a1_r;
      out_beat.out_arg2 <= 6'd0;
      out_beat.last <= is_read_r || (cnt_r == LW'(0));
    end else if (cmd.emit_nb) begin
      out_beat.kind <= 1'b0;
      out_beat.task_type <= (ctype_r == gcte_pkg::TT_SEND) ? gcte_pkg::TT_RECV_DEG : ctype_r;
      out_beat.task_vertex <= 12'(nb_r);
      out_beat.out_arg0 <= {deg_r, 16'd0};
      out_beat.out_arg1 <= 32'(vi);
      out_beat.out_arg2 <= child_a2_r;
      out_beat.last <= (cnt_r == LW'(1));
    end else if (cmd.emit_enq) begin
      out_beat.kind <= 1'b0;
      out_beat.task_type <= gcte_pkg::TT_SEND;
      out_beat.task_vertex <= enq_i_r[11:0];
      out_beat.out_arg0 <= 32'd0;
      out_beat.out_arg1 <= 32'd0;
      out_beat.out_arg2 <= 6'd0;
      out_beat.last <= (cnt_r == LW'(1));
    end
  end

endmodule
`default_nettype wire

/* rtl/graph_coloring_task_engine_top.sv */
// Top level of the graph coloring task engine.
`default_nettype none
// Usage: pulse start with a task on in_beat while busy is low; the task is taken
// at that edge and busy rises until every result beat has been sent.
// Results appear on out_beat, one per cycle while out_valid is high, each for
// exactly one cycle; the receiver cannot stall, and last marks the final beat.
// The first beat follows the vertex read, update and setup states for reads
// and range enqueues; tasks that walk the neighbor store also pass a dispatch
// state, since their window bounds are registered at setup before the first
// neighbor read. Busy covers the vertex read, update and setup states, the
// dispatch state for a neighbor walk, then the result beats; loads and tasks
// with no results return to idle without a beat. The engine takes one task at
// a time: the next task is taken only in the idle state.
// Configuration: cfg_we writes cfg_idx (0 vertex count, 1 chunk limit) from
// cfg_wdata; the user writes only while the engine is idle (not enforced).
// Reset (rst_n low, synchronous) returns the controller to idle and the
// configuration registers and out_valid to their defaults; vertex and edge
// stores hold no defined value until loaded.
module graph_coloring_task_engine_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  gcte_pkg::in_beat_t        in_beat,
  output logic                      out_valid,
  output gcte_pkg::out_beat_t       out_beat,
  input  wire logic                 cfg_we,
  input  wire logic [0:0]           cfg_idx,
  input  wire logic [12:0]          cfg_wdata
);

  gcte_pkg::dp_cmd_t cmd;
  gcte_pkg::dp_sts_t sts;

  gcte_ctrl u_ctrl (.clk, .rst_n, .start, .busy, .sts, .cmd);

  gcte_dp u_dp (.clk, .rst_n, .cfg_we, .cfg_idx, .cfg_wdata, .in_beat,
                .cmd, .sts, .out_valid, .out_beat);

`ifndef SYNTHESIS
  a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result beat without a task");
  a_read_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.kind) |-> out_beat.last) else $error("read reply not last");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.last) |-> !busy) else $error("busy after last beat");
`endif

endmodule
`default_nettype wire
